// ===== hw/rtl/mbv_pkg.sv =====
`default_nettype none

package mbv_pkg;

  // sizing of the datapath
  localparam int SAMPLE_WIDTH = 16;
  localparam int COUNT_WIDTH  = 16;
  localparam int FRAC_BITS    = 8;

  localparam int SUM_W    = SAMPLE_WIDTH + COUNT_WIDTH;
  localparam int SQR_W    = 2 * SAMPLE_WIDTH - 1;
  localparam int SQ_W     = SQR_W + COUNT_WIDTH;
  localparam int SQ_LO_W  = (SQ_W + 1) / 2;
  localparam int SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int NUM_W    = COUNT_WIDTH + SQ_W;
  localparam int DIV_W    = NUM_W + FRAC_BITS;
  localparam int DEN_W    = 2 * COUNT_WIDTH;
  localparam int DCNT_W   = $clog2(DIV_W);

  // result field widths
  localparam int MEAN_W    = 24;
  localparam int VAR_W     = 39;
  localparam int CNT_OUT_W = 16;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SHORT    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL1,
    B_MUL2,
    B_ADD,
    B_SUB,
    B_DIVM,
    B_DIVV,
    B_DONE
  } back_state_t;

  // totals of one finished block
  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sumsq;
    logic [COUNT_WIDTH-1:0]  count;
    logic                    ovf;
  } mbv_block_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbv_front.sv =====
`default_nettype none

module mbv_front
  import mbv_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           last,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           q_full,
  output logic                                q_push,
  output mbv_block_t                          q_data
);

  logic                           a_valid;
  logic signed [SAMPLE_WIDTH-1:0] a_smp;
  logic [SQR_W-1:0]               a_sq;
  logic                           a_last;
  logic                           a_go;
  logic                           in_xfer;
  logic signed [2*SAMPLE_WIDTH-1:0] sq_full;
  mbv_block_t                     acc;
  mbv_block_t                     acc_next;

  // stage a advances unless a block end waits for queue room
  assign a_go     = a_valid && (!a_last || !q_full);
  assign in_ready = !a_valid || a_go;
  assign in_xfer  = in_valid && in_ready;
  assign sq_full  = sample * sample;

  // square register ahead of the accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
    if (in_xfer) begin
      a_smp  <= sample;
      a_sq   <= SQR_W'(sq_full);
      a_last <= last;
    end
  end

  // accumulate, or mark overflow once the count is full
  always_comb begin
    acc_next = acc;
    if (a_go) begin
      if (acc.count != CNT_MAX) begin
        acc_next.sum   = acc.sum + SUM_W'(a_smp);
        acc_next.sumsq = acc.sumsq + SQ_W'(a_sq);
        acc_next.count = acc.count + 1'b1;
      end else begin
        acc_next.ovf = 1'b1;
      end
    end
  end

  assign q_push = a_go && a_last;
  assign q_data = acc_next;

  always_ff @(posedge clk) begin
    if (rst || q_push) begin
      acc <= '0;
    end else begin
      acc <= acc_next;
    end
  end

  // a block end leaves the accumulators clear
  a_clear_after_push: assert property (@(posedge clk) disable iff (rst)
    q_push |=> (acc.count == '0 && !acc.ovf && acc.sum == '0 && acc.sumsq == '0))
    else $error("accumulators not cleared after block end");

  // a full count holds and raises overflow
  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    (a_go && !a_last && acc.count == CNT_MAX) |=> (acc.count == CNT_MAX && acc.ovf))
    else $error("full count did not hold");

endmodule

`default_nettype wire

// ===== hw/rtl/mbv_fifo.sv =====
`default_nettype none

module mbv_fifo
  import mbv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire mbv_block_t push_data,
  output logic            full,
  input  wire logic       pop,
  output mbv_block_t      pop_data,
  output logic            empty
);

  mbv_block_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     fill;

  assign full     = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  a_no_bad_access: assert property (@(posedge clk) disable iff (rst)
    !(push && full) && !(pop && empty))
    else $error("queue pushed when full or popped when empty");

endmodule

`default_nettype wire

// ===== hw/rtl/mbv_div.sv =====
`default_nettype none

module mbv_div
  import mbv_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output logic                  done,
  output logic [DIV_W-1:0]      quotient
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [DIV_W-1:0]  quo;
  logic [DEN_W-1:0]  rem;
  logic [DEN_W-1:0]  dvs;
  logic [DEN_W:0]    shifted;
  logic              ge;
  logic [DEN_W:0]    diff;

  // one restoring step: bring down a bit, subtract if it fits
  assign shifted  = {rem, quo[DIV_W-1]};
  assign ge       = (shifted >= {1'b0, dvs});
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in as dividend bits shift out
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DIV_W-2:0], ge};
      rem <= ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/mbv_back.sv =====
`default_nettype none

module mbv_back
  import mbv_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_empty,
  output logic                   q_pop,
  input  wire mbv_block_t        q_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [MEAN_W-1:0] mean_q8,
  output logic [VAR_W-1:0]       variance_q8,
  output logic [CNT_OUT_W-1:0]   sample_count,
  output logic [1:0]             status
);

  back_state_t state, state_next;

  logic [COUNT_WIDTH-1:0]         n;
  logic [SUM_W-1:0]               mag;
  logic                           neg;
  logic [SQ_W-1:0]                sumsq;
  logic                           ovf;
  logic [COUNT_WIDTH+SQ_LO_W-1:0] p_lo;
  logic [COUNT_WIDTH+SQ_HI_W-1:0] p_hi;
  logic [2*SUM_W-1:0]             magsq;
  logic [DEN_W-1:0]               den;
  logic [NUM_W-1:0]               nsq;
  logic [NUM_W-1:0]               num;
  logic [MEAN_W-1:0]              mean_r;
  logic [VAR_W-1:0]               var_r;
  logic                           multi;

  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic [DEN_W-1:0] div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_quo;
  logic             out_load;
  status_t          st;

  assign multi = (n >= COUNT_WIDTH'(2));

  mbv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and strobes
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    out_load     = 1'b0;
    div_dividend = DIV_W'({num, FRAC_BITS'(0)});
    div_divisor  = den;
    unique case (state)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = B_MUL1;
        end
      end
      B_MUL1: state_next = B_MUL2;
      B_MUL2: state_next = B_ADD;
      B_ADD:  state_next = B_SUB;
      B_SUB: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'({mag, FRAC_BITS'(0)});
        div_divisor  = DEN_W'(n);
        state_next   = B_DIVM;
      end
      B_DIVM: begin
        if (div_done) begin
          if (multi) begin
            div_start  = 1'b1;
            state_next = B_DIVV;
          end else begin
            state_next = B_DONE;
          end
        end
      end
      B_DIVV: begin
        if (div_done) begin
          state_next = B_DONE;
        end
      end
      B_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        n     <= q_data.count;
        neg   <= q_data.sum[SUM_W-1];
        mag   <= q_data.sum[SUM_W-1] ? SUM_W'(-q_data.sum) : SUM_W'(q_data.sum);
        sumsq <= q_data.sumsq;
        ovf   <= q_data.ovf;
        var_r <= '0;
      end
      B_MUL1: begin
        p_lo  <= n * sumsq[SQ_LO_W-1:0];
        magsq <= mag * mag;
      end
      B_MUL2: begin
        p_hi <= n * sumsq[SQ_W-1:SQ_LO_W];
        den  <= n * (n - 1'b1);
      end
      B_ADD: begin
        nsq <= NUM_W'({p_hi, SQ_LO_W'(0)}) + NUM_W'(p_lo);
      end
      B_SUB: begin
        num <= nsq - magsq[NUM_W-1:0];
      end
      B_DIVM: begin
        if (div_done) begin
          mean_r <= neg ? MEAN_W'(-div_quo) : MEAN_W'(div_quo);
        end
      end
      B_DIVV: begin
        if (div_done) begin
          var_r <= VAR_W'(div_quo);
        end
      end
      default: ;
    endcase
  end

  // overflow outranks the short-block status
  always_comb begin
    if (ovf) begin
      st = ST_OVERFLOW;
    end else if (!multi) begin
      st = ST_SHORT;
    end else begin
      st = ST_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      mean_q8      <= mean_r;
      variance_q8  <= var_r;
      sample_count <= CNT_OUT_W'(n);
      status       <= st;
    end
  end

  a_short_zero_var: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_SHORT) |-> (variance_q8 == '0))
    else $error("short block with nonzero variance");

endmodule

`default_nettype wire

// ===== hw/rtl/block_mean_and_sample_variance.sv =====
// Block mean and sample variance over a stream of signed samples.
//
// Input channel: sample, last with in_valid / in_ready. Every transfer adds one
// sample to the running sum, sum of squares and count; a transfer with last
// set closes the block. Past the full count further samples are dropped and
// the block reports overflow.
// Output channel: mean_q8, variance_q8, sample_count, status with out_valid /
// out_ready, one result per block, in block order.
// Throughput: one sample per cycle while a block accumulates and no block end
// waits for queue room. The back end works on one block at a time, its time
// per block set by the shared radix-2 divider doing the mean, then the
// variance; a single-sample block skips the variance.
// A two-entry queue of block totals sits between the two halves, so the input
// stalls only while the queue is full, i.e. with very short blocks.
// A stalled receiver holds the result in the output register; the back end
// stops at its final step and the queue and front keep taking samples.
// Reset (rst, synchronous) clears the accumulators, the queue and out_valid.
`default_nettype none

module block_mean_and_sample_variance
  import mbv_pkg::*;
(
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic signed [SAMPLE_WIDTH-1:0] sample,
  input  wire logic                           last,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic signed [MEAN_W-1:0]            mean_q8,
  output logic [VAR_W-1:0]                    variance_q8,
  output logic [CNT_OUT_W-1:0]                sample_count,
  output logic [1:0]                          status
);

  logic       q_full;
  logic       q_empty;
  logic       q_push;
  logic       q_pop;
  mbv_block_t q_wdata;
  mbv_block_t q_rdata;

  mbv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .sample   (sample),
    .last     (last),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  mbv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  mbv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_data       (q_rdata),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .mean_q8      (mean_q8),
    .variance_q8  (variance_q8),
    .sample_count (sample_count),
    .status       (status)
  );

endmodule

`default_nettype wire
